@@ hdl/ttf_pkg.sv @@
// ----------------------------------------------------------------------------
// ttf_pkg
// Shared widths, the vector type and Q1.14 rounding for the tangent frame.
// ----------------------------------------------------------------------------
`default_nettype none

package ttf_pkg;

	localparam int Q14_W   = 16;
	localparam int ONE_Q14 = 16384;
	localparam int M_W     = 30;
	localparam int SQ_W    = 2 * M_W;
	localparam int SUM_W   = 62;
	localparam int ROOT_W  = 31;
	localparam int QUO_W   = 15;
	localparam int REM_W   = 46;
	localparam int FRAC_W  = 14;
	localparam int PRD_W   = 2 * Q14_W;

	typedef logic [2:0][Q14_W-1:0] vec_t;

	// round half up from Q4.28 to Q1.14, then clamp
	function automatic logic [Q14_W-1:0] round_sat(input logic [PRD_W:0] x);
		logic signed [PRD_W+1:0] y;
		logic signed [PRD_W-FRAC_W+1:0] r;
		y = $signed({x[PRD_W], x}) + $signed((PRD_W+2)'(ONE_Q14 / 2));
		r = y[PRD_W+1:FRAC_W];
		if (r > $signed((PRD_W-FRAC_W+2)'(ONE_Q14)))
			return Q14_W'(ONE_Q14);
		else if (r < -$signed((PRD_W-FRAC_W+2)'(ONE_Q14)))
			return Q14_W'(-ONE_Q14);
		else
			return r[Q14_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ hdl/ttf_unit.sv @@
// ----------------------------------------------------------------------------
// ttf_unit
// Edge to unit vector: difference, normalize, sum of squares, pipelined
// square root (one bit per stage) and three pipelined restoring dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module ttf_unit #(
	parameter int CW = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  vld,
	input  wire logic [2:0][CW-1:0]    tip,
	input  wire logic [2:0][CW-1:0]    base,
	output logic                       vld_out,
	output ttf_pkg::vec_t              u,
	output logic                       zro
);

	localparam int DW  = CW + 1;
	localparam int LZW = $clog2(CW + 1);
	localparam int WW  = DW + ttf_pkg::M_W;
	localparam int SQS = ttf_pkg::ROOT_W;
	localparam int DVS = ttf_pkg::QUO_W;

	// stage 1: difference and magnitude
	logic [2:0][DW-1:0] dif;
	logic               vld_s1;
	logic [2:0]         sgn_s1;
	logic [2:0][DW-1:0] mag_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dif[i] = {tip[i][CW-1], tip[i]} - {base[i][CW-1], base[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= vld;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sgn_s1[i] <= dif[i][DW-1];
			mag_s1[i] <= dif[i][DW-1] ? -dif[i] : dif[i];
		end
	end

	// stage 2: leading one of the largest magnitude
	logic [DW-1:0]      orv;
	logic [LZW-1:0]     lz_c;
	logic               vld_s2;
	logic [2:0]         sgn_s2;
	logic [2:0][DW-1:0] mag_s2;
	logic [LZW-1:0]     lz_s2;
	logic               zro_s2;

	assign orv = mag_s1[0] | mag_s1[1] | mag_s1[2];

	always_comb begin
		lz_c = '0;
		for (int j = 0; j < DW; j++) begin
			if (orv[j]) lz_c = LZW'(CW - j);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		sgn_s2 <= sgn_s1;
		mag_s2 <= mag_s1;
		lz_s2  <= lz_c;
		zro_s2 <= (orv == '0);
	end

	// stage 3: scale so the top bit lands at bit 29
	logic [2:0][WW-1:0]            wide;
	logic                          vld_s3;
	logic [2:0]                    sgn_s3;
	logic                          zro_s3;
	logic [2:0][ttf_pkg::M_W-1:0]  m_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wide[i] = {mag_s2[i], {ttf_pkg::M_W{1'b0}}} << lz_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		sgn_s3 <= sgn_s2;
		zro_s3 <= zro_s2;
		for (int i = 0; i < 3; i++) begin
			m_s3[i] <= wide[i][WW-1 -: ttf_pkg::M_W];
		end
	end

	// stage 4: squares
	logic                          vld_s4;
	logic [2:0]                    sgn_s4;
	logic                          zro_s4;
	logic [2:0][ttf_pkg::M_W-1:0]  m_s4;
	logic [2:0][ttf_pkg::SQ_W-1:0] sq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else         vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		sgn_s4 <= sgn_s3;
		zro_s4 <= zro_s3;
		m_s4   <= m_s3;
		for (int i = 0; i < 3; i++) begin
			sq_s4[i] <= ttf_pkg::SQ_W'(m_s3[i]) * ttf_pkg::SQ_W'(m_s3[i]);
		end
	end

	// stage 5: sum of squares
	logic                          vld_s5;
	logic [2:0]                    sgn_s5;
	logic                          zro_s5;
	logic [2:0][ttf_pkg::M_W-1:0]  m_s5;
	logic [ttf_pkg::SUM_W-1:0]     sum_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else         vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		sgn_s5 <= sgn_s4;
		zro_s5 <= zro_s4;
		m_s5   <= m_s4;
		sum_s5 <= ttf_pkg::SUM_W'(sq_s4[0]) + ttf_pkg::SUM_W'(sq_s4[1])
			+ ttf_pkg::SUM_W'(sq_s4[2]);
	end

	// square root, one result bit per stage
	logic                          vld_sr [0:SQS];
	logic [2:0]                    sgn_sr [0:SQS];
	logic                          zro_sr [0:SQS];
	logic [2:0][ttf_pkg::M_W-1:0]  m_sr   [0:SQS];
	logic [ttf_pkg::SUM_W-1:0]     rem_sr [0:SQS];
	logic [ttf_pkg::ROOT_W-1:0]    root_sr[0:SQS];

	assign vld_sr[0]  = vld_s5;
	assign sgn_sr[0]  = sgn_s5;
	assign zro_sr[0]  = zro_s5;
	assign m_sr[0]    = m_s5;
	assign rem_sr[0]  = sum_s5;
	assign root_sr[0] = '0;

	for (genvar k = 0; k < SQS; k++) begin : g_sqrt
		localparam int B = SQS - 1 - k;
		logic [ttf_pkg::SUM_W:0] trial;

		assign trial = ((ttf_pkg::SUM_W+1)'(root_sr[k]) << (B + 1))
			+ ((ttf_pkg::SUM_W+1)'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_sr[k+1] <= 1'b0;
			else         vld_sr[k+1] <= vld_sr[k];
		end

		always_ff @(posedge clk) begin
			sgn_sr[k+1] <= sgn_sr[k];
			zro_sr[k+1] <= zro_sr[k];
			m_sr[k+1]   <= m_sr[k];
			if ({1'b0, rem_sr[k]} >= trial) begin
				rem_sr[k+1]  <= rem_sr[k] - trial[ttf_pkg::SUM_W-1:0];
				root_sr[k+1] <= root_sr[k] | (ttf_pkg::ROOT_W'(1) << B);
			end else begin
				rem_sr[k+1]  <= rem_sr[k];
				root_sr[k+1] <= root_sr[k];
			end
		end
	end

	// rounded division m * 2^14 / L, one quotient bit per stage
	logic                           vld_dv [0:DVS];
	logic [2:0]                     sgn_dv [0:DVS];
	logic                           zro_dv [0:DVS];
	logic [ttf_pkg::ROOT_W-1:0]     dvs_dv [0:DVS];
	logic [2:0][ttf_pkg::REM_W-1:0] rem_dv [0:DVS];
	logic [2:0][ttf_pkg::QUO_W-1:0] quo_dv [0:DVS];

	assign vld_dv[0] = vld_sr[SQS];
	assign sgn_dv[0] = sgn_sr[SQS];
	assign zro_dv[0] = zro_sr[SQS];
	assign dvs_dv[0] = root_sr[SQS];
	assign quo_dv[0] = '0;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rem_dv[0][i] = ttf_pkg::REM_W'({m_sr[SQS][i], {ttf_pkg::FRAC_W{1'b0}}})
				+ ttf_pkg::REM_W'(root_sr[SQS] >> 1);
		end
	end

	for (genvar k = 0; k < DVS; k++) begin : g_div
		localparam int B = DVS - 1 - k;
		logic [ttf_pkg::REM_W-1:0] dsh;

		assign dsh = ttf_pkg::REM_W'(dvs_dv[k]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_dv[k+1] <= 1'b0;
			else         vld_dv[k+1] <= vld_dv[k];
		end

		always_ff @(posedge clk) begin
			sgn_dv[k+1] <= sgn_dv[k];
			zro_dv[k+1] <= zro_dv[k];
			dvs_dv[k+1] <= dvs_dv[k];
			for (int i = 0; i < 3; i++) begin
				if (rem_dv[k][i] >= dsh) begin
					rem_dv[k+1][i] <= rem_dv[k][i] - dsh;
					quo_dv[k+1][i] <= quo_dv[k][i] | (ttf_pkg::QUO_W'(1) << B);
				end else begin
					rem_dv[k+1][i] <= rem_dv[k][i];
					quo_dv[k+1][i] <= quo_dv[k][i];
				end
			end
		end
	end

	// output register: sign and zero vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_out <= 1'b0;
		else         vld_out <= vld_dv[DVS];
	end

	always_ff @(posedge clk) begin
		zro <= zro_dv[DVS];
		for (int i = 0; i < 3; i++) begin
			if (zro_dv[DVS])
				u[i] <= '0;
			else if (sgn_dv[DVS][i])
				u[i] <= -ttf_pkg::Q14_W'(quo_dv[DVS][i]);
			else
				u[i] <= ttf_pkg::Q14_W'(quo_dv[DVS][i]);
		end
	end

endmodule

`default_nettype wire

@@ hdl/ttf_cross.sv @@
// ----------------------------------------------------------------------------
// ttf_cross
// Two-stage Q1.14 cross product: products, then difference, round, clamp.
// A side word travels alongside unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module ttf_cross #(
	parameter int SW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          vld,
	input  wire ttf_pkg::vec_t a,
	input  wire ttf_pkg::vec_t b,
	input  wire logic [SW-1:0] side,
	output logic               vld_out,
	output ttf_pkg::vec_t      o,
	output logic [SW-1:0]      side_out
);

	logic                            vld_s1;
	logic [SW-1:0]                   side_s1;
	logic [5:0][ttf_pkg::PRD_W-1:0]  p_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_out <= 1'b0;
		end else begin
			vld_s1  <= vld;
			vld_out <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= side;
		p_s1[0] <= $signed(a[1]) * $signed(b[2]);
		p_s1[1] <= $signed(a[2]) * $signed(b[1]);
		p_s1[2] <= $signed(a[2]) * $signed(b[0]);
		p_s1[3] <= $signed(a[0]) * $signed(b[2]);
		p_s1[4] <= $signed(a[0]) * $signed(b[1]);
		p_s1[5] <= $signed(a[1]) * $signed(b[0]);
	end

	always_ff @(posedge clk) begin
		side_out <= side_s1;
		for (int k = 0; k < 3; k++) begin
			o[k] <= ttf_pkg::round_sat({p_s1[2*k][ttf_pkg::PRD_W-1], p_s1[2*k]}
				- {p_s1[2*k+1][ttf_pkg::PRD_W-1], p_s1[2*k+1]});
		end
	end

endmodule

`default_nettype wire

@@ hdl/triangle_tangent_frame.sv @@
// ----------------------------------------------------------------------------
// triangle_tangent_frame
// Throughput: one request per cycle.
// Depth is set by the 31-stage square root and 15-stage dividers.
// busy is always low; results cannot be held off by the receiver.
// Reset clears only the valid pipeline; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_tangent_frame #(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [COORD_WIDTH-1:0] corner_a_x,
	input  wire logic signed [COORD_WIDTH-1:0] corner_a_y,
	input  wire logic signed [COORD_WIDTH-1:0] corner_a_z,
	input  wire logic signed [COORD_WIDTH-1:0] corner_b_x,
	input  wire logic signed [COORD_WIDTH-1:0] corner_b_y,
	input  wire logic signed [COORD_WIDTH-1:0] corner_b_z,
	input  wire logic signed [COORD_WIDTH-1:0] corner_c_x,
	input  wire logic signed [COORD_WIDTH-1:0] corner_c_y,
	input  wire logic signed [COORD_WIDTH-1:0] corner_c_z,
	output logic                               done,
	output logic signed [15:0]                 tan_x,
	output logic signed [15:0]                 tan_y,
	output logic signed [15:0]                 tan_z,
	output logic signed [15:0]                 bit_x,
	output logic signed [15:0]                 bit_y,
	output logic signed [15:0]                 bit_z,
	output logic signed [15:0]                 nrm_x,
	output logic signed [15:0]                 nrm_y,
	output logic signed [15:0]                 nrm_z,
	output logic                               degenerate
);

	localparam int VW  = 3 * ttf_pkg::Q14_W;
	localparam int SW1 = VW + 1;
	localparam int SW2 = 2 * VW + 1;

	logic [2:0][COORD_WIDTH-1:0] ca, cb, cc;
	logic                        req;
	logic                        vld_t, vld_b, zro_t, zro_b;
	ttf_pkg::vec_t               t_u, b_u;
	logic                        vld_c1, vld_c2;
	ttf_pkg::vec_t               n_c1, b_c2;
	logic [SW1-1:0]              side_c1;
	logic [SW2-1:0]              side_c2;
	ttf_pkg::vec_t               t_c1, t_c2, n_c2;

	assign busy = 1'b0;
	assign req  = start & ~busy;

	assign ca = {corner_a_z, corner_a_y, corner_a_x};
	assign cb = {corner_b_z, corner_b_y, corner_b_x};
	assign cc = {corner_c_z, corner_c_y, corner_c_x};

	ttf_unit #(.CW(COORD_WIDTH)) u_tan (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (req),
		.tip    (cc),
		.base   (cb),
		.vld_out(vld_t),
		.u      (t_u),
		.zro    (zro_t)
	);

	ttf_unit #(.CW(COORD_WIDTH)) u_bit (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (req),
		.tip    (ca),
		.base   (cb),
		.vld_out(vld_b),
		.u      (b_u),
		.zro    (zro_b)
	);

	ttf_cross #(.SW(SW1)) u_nrm (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (vld_t & vld_b),
		.a       (t_u),
		.b       (b_u),
		.side    ({zro_t | zro_b, t_u}),
		.vld_out (vld_c1),
		.o       (n_c1),
		.side_out(side_c1)
	);

	assign t_c1 = side_c1[VW-1:0];

	ttf_cross #(.SW(SW2)) u_fin (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (vld_c1),
		.a       (n_c1),
		.b       (t_c1),
		.side    ({side_c1[VW], n_c1, t_c1}),
		.vld_out (vld_c2),
		.o       (b_c2),
		.side_out(side_c2)
	);

	assign t_c2 = side_c2[VW-1:0];
	assign n_c2 = side_c2[2*VW-1:VW];

	assign done       = vld_c2;
	assign degenerate = side_c2[2*VW];
	assign tan_x      = t_c2[0];
	assign tan_y      = t_c2[1];
	assign tan_z      = t_c2[2];
	assign bit_x      = b_c2[0];
	assign bit_y      = b_c2[1];
	assign bit_z      = b_c2[2];
	assign nrm_x      = n_c2[0];
	assign nrm_y      = n_c2[1];
	assign nrm_z      = n_c2[2];

endmodule

`default_nettype wire

@@ dv/ttf_frame_checker.sv @@
// ----------------------------------------------------------------------------
// ttf_frame_checker
// Watches requests and done strobes of the tangent frame block, predicts each
// frame from the corners in fixed point and compares results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module ttf_frame_checker #(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          busy,
	input  wire logic signed [COORD_WIDTH-1:0] corner_a_x,
	input  wire logic signed [COORD_WIDTH-1:0] corner_a_y,
	input  wire logic signed [COORD_WIDTH-1:0] corner_a_z,
	input  wire logic signed [COORD_WIDTH-1:0] corner_b_x,
	input  wire logic signed [COORD_WIDTH-1:0] corner_b_y,
	input  wire logic signed [COORD_WIDTH-1:0] corner_b_z,
	input  wire logic signed [COORD_WIDTH-1:0] corner_c_x,
	input  wire logic signed [COORD_WIDTH-1:0] corner_c_y,
	input  wire logic signed [COORD_WIDTH-1:0] corner_c_z,
	input  wire logic                          done,
	input  wire logic signed [15:0]            tan_x,
	input  wire logic signed [15:0]            tan_y,
	input  wire logic signed [15:0]            tan_z,
	input  wire logic signed [15:0]            bit_x,
	input  wire logic signed [15:0]            bit_y,
	input  wire logic signed [15:0]            bit_z,
	input  wire logic signed [15:0]            nrm_x,
	input  wire logic signed [15:0]            nrm_y,
	input  wire logic signed [15:0]            nrm_z,
	input  wire logic                          degenerate,
	output int                                 errors,
	output int                                 pending
);

	typedef longint signed v3_t [3];

	typedef struct {
		logic signed [15:0] t [3];
		logic signed [15:0] b [3];
		logic signed [15:0] n [3];
		logic               degen;
	} frame_t;

	frame_t frame_q [$];

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic bit normalize(input v3_t d, output v3_t u);
		longint unsigned m [3];
		longint unsigned mx, sum, len, q;
		int p;
		mx = 0;
		sum = 0;
		p = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = d[i] < 0 ? -d[i] : d[i];
			if (m[i] > mx) mx = m[i];
		end
		for (int i = 0; i < 3; i++) u[i] = 0;
		if (mx == 0) return 1'b0;
		while (p < 63 && (mx >> (p + 1)) != 0) p++;
		for (int i = 0; i < 3; i++) begin
			if (p > 29) m[i] >>= (p - 29);
			else if (p < 29) m[i] <<= (29 - p);
			sum += m[i] * m[i];
		end
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = (m[i] * 16384 + len / 2) / len;
			if (q > 16384) q = 16384;
			u[i] = d[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1'b1;
	endfunction

	function automatic longint q14_round(input longint x);
		longint y, r;
		y = x + 8192;
		if (y >= 0) r = y >>> 14;
		else r = -((-y + 16383) >>> 14);
		if (r > 16384) r = 16384;
		if (r < -16384) r = -16384;
		return r;
	endfunction

	function automatic void cross_q14(input v3_t a, input v3_t b, output v3_t o);
		o[0] = q14_round(a[1] * b[2] - a[2] * b[1]);
		o[1] = q14_round(a[2] * b[0] - a[0] * b[2]);
		o[2] = q14_round(a[0] * b[1] - a[1] * b[0]);
	endfunction

	function automatic frame_t predict_frame(input v3_t ca, input v3_t cb, input v3_t cc);
		v3_t et, eb, t, b0, n, b;
		frame_t f;
		bit ok_t, ok_b;
		for (int i = 0; i < 3; i++) begin
			et[i] = cc[i] - cb[i];
			eb[i] = ca[i] - cb[i];
		end
		ok_t = normalize(et, t);
		ok_b = normalize(eb, b0);
		cross_q14(t, b0, n);
		cross_q14(n, t, b);
		for (int i = 0; i < 3; i++) begin
			f.t[i] = t[i][15:0];
			f.b[i] = b[i][15:0];
			f.n[i] = n[i][15:0];
		end
		f.degen = !(ok_t && ok_b);
		return f;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		v3_t ca, cb, cc;
		frame_t e;
		logic signed [15:0] gt [3], gb [3], gn [3];
		if (arst_n) begin
			if (start && !busy) begin
				ca = '{longint'(corner_a_x), longint'(corner_a_y), longint'(corner_a_z)};
				cb = '{longint'(corner_b_x), longint'(corner_b_y), longint'(corner_b_z)};
				cc = '{longint'(corner_c_x), longint'(corner_c_y), longint'(corner_c_z)};
				e = predict_frame(ca, cb, cc);
				frame_q = {frame_q, e};
			end
			if (done) begin
				if (frame_q.size() == 0) begin
					report("unexpected done", 1, 0);
				end else begin
					e = frame_q.pop_front();
					gt = '{tan_x, tan_y, tan_z};
					gb = '{bit_x, bit_y, bit_z};
					gn = '{nrm_x, nrm_y, nrm_z};
					for (int i = 0; i < 3; i++) begin
						if (gt[i] !== e.t[i]) report($sformatf("tan[%0d]", i), gt[i], e.t[i]);
						if (gb[i] !== e.b[i]) report($sformatf("bit[%0d]", i), gb[i], e.b[i]);
						if (gn[i] !== e.n[i]) report($sformatf("nrm[%0d]", i), gn[i], e.n[i]);
					end
					if (degenerate !== e.degen) report("degenerate", degenerate, e.degen);
				end
			end
			pending <= frame_q.size();
		end
	end

endmodule

`default_nettype wire

@@ dv/tb_triangle_tangent_frame.sv @@
// ----------------------------------------------------------------------------
// tb_triangle_tangent_frame
// Drives directed and random triangles into the tangent frame block in bursts
// and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_triangle_tangent_frame;

	localparam int CW = 32;
	localparam int LIMIT = 200000;

	logic clk, arst_n, start, busy, done, degenerate;
	logic signed [CW-1:0] crn [9];
	logic signed [15:0] tan_x, tan_y, tan_z, bit_x, bit_y, bit_z, nrm_x, nrm_y, nrm_z;
	int errors, pending, cycles;

	triangle_tangent_frame #(.COORD_WIDTH(CW)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.corner_a_x(crn[0]), .corner_a_y(crn[1]), .corner_a_z(crn[2]),
		.corner_b_x(crn[3]), .corner_b_y(crn[4]), .corner_b_z(crn[5]),
		.corner_c_x(crn[6]), .corner_c_y(crn[7]), .corner_c_z(crn[8]),
		.done(done), .tan_x(tan_x), .tan_y(tan_y), .tan_z(tan_z),
		.bit_x(bit_x), .bit_y(bit_y), .bit_z(bit_z),
		.nrm_x(nrm_x), .nrm_y(nrm_y), .nrm_z(nrm_z), .degenerate(degenerate)
	);

	ttf_frame_checker #(.COORD_WIDTH(CW)) chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.corner_a_x(crn[0]), .corner_a_y(crn[1]), .corner_a_z(crn[2]),
		.corner_b_x(crn[3]), .corner_b_y(crn[4]), .corner_b_z(crn[5]),
		.corner_c_x(crn[6]), .corner_c_y(crn[7]), .corner_c_z(crn[8]),
		.done(done), .tan_x(tan_x), .tan_y(tan_y), .tan_z(tan_z),
		.bit_x(bit_x), .bit_y(bit_y), .bit_z(bit_z),
		.nrm_x(nrm_x), .nrm_y(nrm_y), .nrm_z(nrm_z), .degenerate(degenerate),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'sd1 <<< $urandom_range(0, 30);
			2: return -(32'sd1 <<< $urandom_range(0, 31));
			3: return $urandom_range(0, 7) - 3;
			4: return $urandom() >>> $urandom_range(0, 31);
			default: return ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000)
				^ $urandom_range(0, 3);
		endcase
	endfunction

	task automatic send(input logic [31:0] v [9]);
		for (int i = 0; i < 9; i++) crn[i] <= v[i];
		start <= 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic pause(input int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	initial begin
		logic [31:0] v [9];
		logic [31:0] mx, mn;
		int burst;
		mx = 32'h7fffffff;
		mn = 32'h80000000;
		start = 0;
		for (int i = 0; i < 9; i++) crn[i] = '0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: right angles, extremes, degenerate edges, rounding corners
		send('{0, 32'h10000, 0, 0, 0, 0, 32'h10000, 0, 0});
		send('{0, 0, 32'h10000, 0, 0, 0, 0, 32'h10000, 0});
		send('{1, 1, 1, 1, 1, 1, 5, 6, 7});
		send('{5, 6, 7, 1, 1, 1, 1, 1, 1});
		send('{3, 3, 3, 3, 3, 3, 3, 3, 3});
		send('{mx, mx, mx, mn, mn, mn, mx, mn, mx});
		send('{mn, mn, mn, mx, mx, mx, mn, mx, mn});
		send('{mx, 0, 0, mn, 0, 0, mx, mx, 0});
		send('{mn, mx, mn, mx, mn, mx, mn, mn, mn});
		send('{1, 0, 0, 0, 0, 0, 2, 0, 0});
		send('{1, 1, 0, 0, 0, 0, 1, 0, 0});
		send('{0, 1, 0, 0, 0, 0, -1, 0, 0});
		send('{1, 2, 3, 0, 0, 0, 3, 2, 1});
		send('{-1, -1, -1, 0, 0, 0, 1, 1, 1});
		send('{mx, mx, mx, 0, 0, 0, 1, 0, 0});
		send('{32'h10001, 32'h7fff, 1, 0, 0, 0, 32'hffff, 1, 32'h3});
		send('{32'hdeadbeef, 32'h12345678, 32'hcafef00d, 32'h0, 32'hffffffff,
			32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f, 32'hf0f0f0f0});
		pause($urandom_range(1, 4));

		for (int k = 0; k < 1900; k++) begin
			for (int i = 0; i < 9; i++) v[i] = rand_coord();
			case ($urandom_range(0, 15))
				0: for (int i = 0; i < 3; i++) v[6 + i] = v[3 + i];
				1: for (int i = 0; i < 3; i++) v[i] = v[3 + i];
				2: for (int i = 0; i < 3; i++) v[i] = v[3 + i] + $urandom_range(0, 2) - 1;
				default: ;
			endcase
			send(v);
			if (k == 950) begin
				start <= 1'b0;
				while (pending != 0) @(negedge clk);
			end
			burst = $urandom_range(0, 3);
			if (burst == 0) pause($urandom_range(1, 12));
		end
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
